// File: rtl/core/sem_pkg.sv
// sem_pkg: shared types and constants of the sobel edge magnitude block
// used by every module of the block but sem_ram; no dependencies
`timescale 1ns / 1ps

package sem_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4095;
   localparam int WID_BITS   = 11;
   localparam int HGT_BITS   = 12;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = HGT_BITS + 1;
   localparam int CSR_BITS   = 12;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WID_BITS-1:0] WIDTH_RESET  = WID_BITS'(640);
   localparam logic [HGT_BITS-1:0] HEIGHT_RESET = HGT_BITS'(480);

   typedef logic [23:0] pixel_type;

   typedef struct packed {
      logic [8:0][23:0] taps;
      logic             frame_end;
   } window_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_STEP,
      BK_EMIT
   } back_state_type;

endpackage

// File: rtl/core/sem_ram.sv
// sem_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/sem_front.sv
// sem_front: request intake, frame counters, line stores and 3x3 window
// depends on sem_pkg and sem_ram
`timescale 1ns / 1ps

module sem_front import sem_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_action,
   input  logic [7:0]          req_in_red,
   input  logic [7:0]          req_in_green,
   input  logic [7:0]          req_in_blue,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_data,
   input  queue_status_type    q_status,
   output logic                q_push,
   output window_type          q_data
);

   logic [WID_BITS-1:0] width_ff, width_in;
   logic [HGT_BITS-1:0] height_ff, height_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [WID_BITS-1:0] pend_ff, pend_in;
   pixel_type           win_ff [9];
   pixel_type           win_in [9];
   logic                b_valid_ff, b_valid_in;
   logic [COL_BITS-1:0] b_col_ff;
   logic [ROW_BITS-1:0] b_row_ff;
   pixel_type           b_pix_ff;

   logic                take, drain;
   logic [WID_BITS-1:0] k_pos, next_col;
   logic [ROW_BITS-1:0] cur_row, next_row;
   logic [COL_BITS-1:0] cur_col;
   pixel_type           cur_pix, up_pix, mid_pix;
   pixel_type           t [9];
   logic                out_ok;
   logic [ROW_BITS-1:0] orow;
   logic [COL_BITS-1:0] ocol;
   logic [WID_BITS-1:0] wclamp;
   logic [HGT_BITS-1:0] hclamp;

   assign req_full = b_valid_ff || q_status.full;
   assign take     = req_push && !req_full;
   assign drain    = (pend_ff != '0);
   assign k_pos    = width_ff + WID_BITS'(1) - pend_ff;

   always_comb begin
      if (!drain) begin
         cur_row = row_ff;
         cur_col = col_ff;
         cur_pix = {req_in_red, req_in_green, req_in_blue};
      end else if (k_pos < width_ff) begin
         cur_row = ROW_BITS'(height_ff);
         cur_col = k_pos[COL_BITS-1:0];
         cur_pix = '0;
      end else begin
         cur_row = ROW_BITS'(height_ff) + ROW_BITS'(1);
         cur_col = '0;
         cur_pix = '0;
      end
   end

   // clamp of written register values
   always_comb begin
      if (csr_data[WID_BITS-1:0] < WID_BITS'(2)) begin
         wclamp = WID_BITS'(2);
      end else if (csr_data[WID_BITS-1:0] > WID_BITS'(MAX_WIDTH)) begin
         wclamp = WID_BITS'(MAX_WIDTH);
      end else begin
         wclamp = csr_data[WID_BITS-1:0];
      end
      if (csr_data[HGT_BITS-1:0] < HGT_BITS'(2)) begin
         hclamp = HGT_BITS'(2);
      end else if (csr_data[HGT_BITS-1:0] > HGT_BITS'(MAX_HEIGHT)) begin
         hclamp = HGT_BITS'(MAX_HEIGHT);
      end else begin
         hclamp = csr_data[HGT_BITS-1:0];
      end
   end

   assign up_pix  = 24'(0);
   assign mid_pix = 24'(0);

   pixel_type ram_up_q, ram_mid_q;

   sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (ram_mid_q),
      .rd_addr (cur_col),
      .rd_data (ram_up_q)
   );

   sem_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_pix_ff),
      .rd_addr (cur_col),
      .rd_data (ram_mid_q)
   );

   // counters and window update from the registered pixel
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      pend_in    = pend_ff;
      b_valid_in = 1'b0;
      next_col   = WID_BITS'(cur_col) + WID_BITS'(1);
      next_row   = cur_row + ROW_BITS'(1);
      for (int i = 0; i < 9; i++) begin
         win_in[i] = win_ff[i];
      end
      if (b_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r*3]   = win_ff[r*3+1];
            win_in[r*3+1] = win_ff[r*3+2];
         end
         win_in[2] = ram_up_q;
         win_in[5] = ram_mid_q;
         win_in[8] = b_pix_ff;
      end
      if (take && !(!drain && req_action)) begin
         b_valid_in = 1'b1;
         if (!drain) begin
            if (next_col >= width_ff) begin
               col_in = '0;
               if (next_row >= ROW_BITS'(height_ff)) begin
                  row_in  = '0;
                  pend_in = width_ff + WID_BITS'(1);
               end else begin
                  row_in = next_row;
               end
            end else begin
               col_in = next_col[COL_BITS-1:0];
            end
         end else begin
            pend_in = pend_ff - WID_BITS'(1);
         end
      end
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = wclamp;
            CSR_IMAGE_HEIGHT: height_in = hclamp;
            default:          width_in  = width_ff;
         endcase
         col_in     = '0;
         row_in     = '0;
         pend_in    = '0;
         b_valid_in = 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_in[i] = '0;
         end
      end
   end

   // window taps of the result that this pixel completes
   always_comb begin
      out_ok = 1'b0;
      orow   = '0;
      ocol   = '0;
      for (int i = 0; i < 9; i++) begin
         t[i] = win_in[i];
      end
      if (b_col_ff == '0) begin
         for (int r = 0; r < 3; r++) begin
            t[r*3]   = win_ff[r*3+1];
            t[r*3+1] = win_ff[r*3+2];
            t[r*3+2] = '0;
         end
         out_ok = (b_row_ff >= ROW_BITS'(2));
         orow   = b_row_ff - ROW_BITS'(2);
         ocol   = COL_BITS'(width_ff - WID_BITS'(1));
      end else begin
         out_ok = (b_row_ff >= ROW_BITS'(1));
         orow   = b_row_ff - ROW_BITS'(1);
         ocol   = b_col_ff - COL_BITS'(1);
      end
      // zero padding outside the frame
      if (orow == '0) begin
         t[0] = '0; t[1] = '0; t[2] = '0;
      end
      if (orow == ROW_BITS'(height_ff) - ROW_BITS'(1)) begin
         t[6] = '0; t[7] = '0; t[8] = '0;
      end
      if (ocol == '0) begin
         t[0] = '0; t[3] = '0; t[6] = '0;
      end
      if (WID_BITS'(ocol) == width_ff - WID_BITS'(1)) begin
         t[2] = '0; t[5] = '0; t[8] = '0;
      end
      for (int i = 0; i < 9; i++) begin
         q_data.taps[i] = t[i] | up_pix | mid_pix;
      end
      q_data.frame_end = (orow == ROW_BITS'(height_ff) - ROW_BITS'(1)) &&
                         (WID_BITS'(ocol) == width_ff - WID_BITS'(1));
   end

   assign q_push = b_valid_ff && out_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         col_ff     <= '0;
         row_ff     <= '0;
         pend_ff    <= '0;
         b_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         pend_ff    <= pend_in;
         b_valid_ff <= b_valid_in;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_col_ff <= cur_col;
         b_row_ff <= cur_row;
         b_pix_ff <= cur_pix;
      end
   end

endmodule

// File: rtl/core/sem_queue.sv
// sem_queue: two-entry queue of windows between front and back
// depends on sem_pkg
`timescale 1ns / 1ps

module sem_queue import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  window_type       push_data,
   input  logic             pop,
   output window_type       pop_data,
   output queue_status_type status
);

   window_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/sem_back.sv
// sem_back: sobel gradients and rounded root per channel, result register
// depends on sem_pkg
`timescale 1ns / 1ps

module sem_back import sem_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  window_type       q_data,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic             rsp_frame_end
);

   back_state_type     state_ff, state_in;
   logic signed [11:0] gx_ff [3];
   logic signed [11:0] gy_ff [3];
   logic [20:0]        sum_ff [3];
   logic [7:0]         root_ff [3];
   logic [2:0]         bit_ff;
   logic               fe_ff;
   logic               out_valid_ff;
   logic [7:0]         out_ff [3];
   logic               out_fe_ff;

   logic signed [11:0] a [3][9];
   logic signed [11:0] gx [3];
   logic signed [11:0] gy [3];
   logic signed [23:0] sqx [3];
   logic signed [23:0] sqy [3];
   logic [7:0]         trial [3];
   logic [16:0]        tval [3];
   logic [7:0]         mag [3];
   logic               load_out;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int i = 0; i < 9; i++) begin
            a[ch][i] = 12'(q_data.taps[i][8*(2-ch) +: 8]);
         end
         gx[ch] = (a[ch][2] + 12'(2) * a[ch][5] + a[ch][8]) -
                  (a[ch][0] + 12'(2) * a[ch][3] + a[ch][6]);
         gy[ch] = (a[ch][6] + 12'(2) * a[ch][7] + a[ch][8]) -
                  (a[ch][0] + 12'(2) * a[ch][1] + a[ch][2]);
         sqx[ch]   = gx_ff[ch] * gx_ff[ch];
         sqy[ch]   = gy_ff[ch] * gy_ff[ch];
         trial[ch] = root_ff[ch] | (8'd1 << bit_ff);
         tval[ch]  = 17'({8'd0, trial[ch]} * {8'd0, trial[ch]}) + 17'(trial[ch]);
         // smallest n with sum <= n*n+n, saturated at 255
         if (sum_ff[ch] == '0) begin
            mag[ch] = 8'd0;
         end else if (root_ff[ch] == 8'd255) begin
            mag[ch] = 8'd255;
         end else begin
            mag[ch] = root_ff[ch] + 8'd1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_STEP;
         BK_STEP:   if (bit_ff == 3'd0) state_in = BK_EMIT;
         BK_EMIT:   if (!out_valid_ff || rsp_pop) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = (state_ff == BK_IDLE) && !q_status.empty;
      load_out = (state_ff == BK_EMIT) && (!out_valid_ff || rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         fe_ff <= q_data.frame_end;
         for (int ch = 0; ch < 3; ch++) begin
            gx_ff[ch] <= gx[ch];
            gy_ff[ch] <= gy[ch];
         end
      end
      if (state_ff == BK_SQUARE) begin
         bit_ff <= 3'd7;
         for (int ch = 0; ch < 3; ch++) begin
            sum_ff[ch]  <= sqx[ch][20:0] + sqy[ch][20:0];
            root_ff[ch] <= 8'd0;
         end
      end
      if (state_ff == BK_STEP) begin
         bit_ff <= bit_ff - 3'd1;
         for (int ch = 0; ch < 3; ch++) begin
            if (21'(tval[ch]) < sum_ff[ch]) begin
               root_ff[ch] <= trial[ch];
            end
         end
      end
      if (load_out) begin
         out_fe_ff <= fe_ff;
         for (int ch = 0; ch < 3; ch++) begin
            out_ff[ch] <= mag[ch];
         end
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];
   assign rsp_frame_end = out_fe_ff;

endmodule

// File: rtl/core/sobel_edge_magnitude_rgb.sv
// sobel_edge_magnitude_rgb: top level of the rgb sobel edge magnitude block
// depends on sem_pkg, sem_front, sem_queue, sem_back
//
// usage:
//  requests are pixels in raster order (req_action low) pushed while req_full
//  is low; after the last pixel of a frame send image_width+1 drain requests
//  (req_action high). a drain request outside the drain phase is dropped.
//  results come out like a queue: while rsp_empty is low the oldest result is
//  on the rsp_ ports, and rsp_pop takes it. rsp_frame_end marks the last
//  pixel of a frame. the result of a pixel is caused by the request that
//  arrives image_width+1 requests later.
//  timing: the front takes a new request only once the last one has had its
//  line store read and then its window update, and while the queue has room;
//  the back works on one result at a time (gradient, square, 8 root steps,
//  emit) and pops the next window only after the emit.
//  a stalled rsp_pop holds the result; the two-entry queue then fills and
//  req_full rises. reset is synchronous: counters clear, width 640, height
//  480; line stores need no clearing. a csr_ write restarts the frame.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb import sem_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_action,
   input  logic [7:0]          req_in_red,
   input  logic [7:0]          req_in_green,
   input  logic [7:0]          req_in_blue,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_red,
   output logic [7:0]          rsp_out_green,
   output logic [7:0]          rsp_out_blue,
   output logic                rsp_frame_end,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   window_type       q_in, q_out;

   sem_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_status     (q_status),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   sem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_out),
      .status    (q_status)
   );

   sem_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_data        (q_out),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
